// ===== hdl/mbd_pkg.sv =====
// Package for the mip-map box downsampler: sizing defaults, register codes,
// the averaging mode and the result beat type.
// No dependencies; every other file of the block imports it.
package mbd_pkg;

  localparam int MBD_MAX_WIDTH_LOG2  = 8;
  localparam int MBD_MAX_HEIGHT_LOG2 = 8;
  localparam int MBD_MAX_COMPONENTS  = 4;

  // depth is never stored per row, so its cap is fixed
  localparam int DEPTH_LOG2_CAP = 8;
  localparam int Z_W            = 8;

  localparam int SAMPLE_W  = 8;
  localparam int CONTRIB_W = 10;
  localparam int SUM_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 4;
  localparam int NCOMP_W   = 3;

  localparam int MBD_OUT_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_LOG2     = 2'd0,
    CFG_HEIGHT_LOG2    = 2'd1,
    CFG_DEPTH_LOG2     = 2'd2,
    CFG_NUM_COMPONENTS = 2'd3
  } cfg_reg_t;

  // the code doubles as the right shift applied to the block sum
  typedef enum logic [1:0] {
    MODE_1D = 2'd1,
    MODE_2D = 2'd2,
    MODE_3D = 2'd3
  } mode_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] avg_value;
    logic                level_done;
  } out_beat_t;

endpackage

// ===== hdl/mbd_if.sv =====
// Valid/ready channel interfaces for the sample stream and the result stream.
// Depends on mbd_pkg for the field widths.
interface mbd_in_if import mbd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mbd_out_if import mbd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] avg_value;
  logic                level_done;

  modport source (output valid, output avg_value, output level_done, input ready);
  modport sink (input valid, input avg_value, input level_done, output ready);
endinterface

// ===== hdl/mbd_out_fifo.sv =====
// Small result queue between the write-back stage and the output channel.
// Depends on mbd_pkg (out_beat_t) and mbd_out_if.
module mbd_out_fifo import mbd_pkg::*; #(
  parameter int DEPTH = MBD_OUT_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  out_beat_t                  push_beat,
  output logic [$clog2(DEPTH+1)-1:0] count,
  mbd_out_if.source                  out_ch
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH+1);

  out_beat_t         buf_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]   count_r, count_nxt;
  logic              pop;

  assign pop              = out_ch.valid && out_ch.ready;
  assign out_ch.valid     = (count_r != '0);
  assign out_ch.avg_value = buf_r[rd_ptr_r].avg_value;
  assign out_ch.level_done = buf_r[rd_ptr_r].level_done;
  assign count            = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_beat;
    end
  end

endmodule

// ===== hdl/mipmap_box_downsample.sv =====
// Top level of the 2x box-filter mip-level downsampler.
// Depends on mbd_pkg, mbd_if (mbd_in_if, mbd_out_if) and mbd_out_fifo.
//
// Samples of one level arrive in raster order (z, y, x, component), one
// component per beat, and the block accepts one beat every clock cycle
// unless the input stalls as below. Each beat passes a read stage, where its
// partial-sum entry is read from a synchronous store, and a write-back stage,
// where the sum is formed and written back; the beat that closes a 2, 2x2 or
// 2x2x2 block pushes its truncated average into a four-beat result queue.
// When two back-to-back beats touch the same entry the second takes the sum
// from a write-back bypass. The input stalls while the results queued plus
// the beat in the write-back stage add up to four, so it can hold off with
// three results waiting. A write to any configuration register restarts the
// level at the first sample.
module mipmap_box_downsample import mbd_pkg::*; #(
  parameter int MAX_WIDTH_LOG2  = MBD_MAX_WIDTH_LOG2,
  parameter int MAX_HEIGHT_LOG2 = MBD_MAX_HEIGHT_LOG2,
  parameter int MAX_COMPONENTS  = MBD_MAX_COMPONENTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  mbd_in_if.sink               in_ch,
  mbd_out_if.source            out_ch
);

  localparam int MW         = MAX_WIDTH_LOG2;
  localparam int MH         = MAX_HEIGHT_LOG2;
  localparam int CW         = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int STORE_SIZE = (1 << (MW-1)) * (1 << (MH-1)) * MAX_COMPONENTS;
  localparam int AW         = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int IW         = MW + MH + 3;
  localparam int CNTW       = $clog2(MBD_OUT_DEPTH+1);

  // configuration
  logic [CFG_W-1:0]   width_log2_r, height_log2_r, depth_log2_r;
  logic [NCOMP_W-1:0] num_components_r;

  // raster position
  logic [MW-1:0]  x_r, x_nxt;
  logic [MH-1:0]  y_r, y_nxt;
  logic [Z_W-1:0] z_r, z_nxt;
  logic [CW-1:0]  c_r, c_nxt;

  // first stage
  logic [CFG_W-1:0]     wl, hl, dl, wsh;
  logic [NCOMP_W-1:0]   comps;
  logic [CW-1:0]        comps_m1;
  logic [MW-1:0]        w_mask;
  logic [MH-1:0]        h_mask;
  logic [Z_W-1:0]       d_mask;
  mode_t                mode;
  logic                 first, last, done;
  logic [1:0]           dup_shift;
  logic [CONTRIB_W-1:0] contrib;
  logic [IW-1:0]        base, idx_full;
  logic [AW-1:0]        addr;
  logic                 in_acc;

  // second stage
  logic                 s1_valid_r;
  logic                 s1_first_r, s1_last_r, s1_done_r, s1_fwd_r;
  mode_t                s1_mode_r;
  logic [CONTRIB_W-1:0] s1_contrib_r;
  logic [AW-1:0]        s1_addr_r;
  logic [SUM_W-1:0]     rd_data_r, fwd_data_r, operand;
  logic [SUM_W:0]       sum_wide;
  logic [SUM_W-1:0]     sum;
  out_beat_t            res_beat;
  logic [CNTW-1:0]      fifo_count;

  logic [SUM_W-1:0] mem [STORE_SIZE];

  // ---------------------------------------------------------------- geometry
  always_comb begin
    wl = (width_log2_r  > CFG_W'(MW)) ? CFG_W'(MW) : width_log2_r;
    hl = (height_log2_r > CFG_W'(MH)) ? CFG_W'(MH) : height_log2_r;
    dl = (depth_log2_r  > CFG_W'(DEPTH_LOG2_CAP)) ? CFG_W'(DEPTH_LOG2_CAP) : depth_log2_r;
    if (num_components_r == '0) begin
      comps = NCOMP_W'(1);
    end else if (num_components_r > NCOMP_W'(MAX_COMPONENTS)) begin
      comps = NCOMP_W'(MAX_COMPONENTS);
    end else begin
      comps = num_components_r;
    end
    comps_m1 = CW'(comps - 1'b1);
    w_mask   = ~({MW{1'b1}} << wl);
    h_mask   = ~({MH{1'b1}} << hl);
    d_mask   = ~({Z_W{1'b1}} << dl);
    wsh      = (wl == '0) ? '0 : wl - 1'b1;
    if (dl != '0) begin
      mode = MODE_3D;
    end else if (hl != '0) begin
      mode = MODE_2D;
    end else begin
      mode = MODE_1D;
    end
  end

  // ------------------------------------------------------ block position flags
  always_comb begin
    first     = ~x_r[0];
    last      = x_r[0] | (wl == '0);
    dup_shift = {1'b0, (wl == '0)};
    if (mode != MODE_1D) begin
      first     = first & ~y_r[0];
      last      = last & (y_r[0] | (hl == '0));
      dup_shift = dup_shift + {1'b0, (hl == '0)};
    end
    if (mode == MODE_3D) begin
      first = first & ~z_r[0];
      last  = last & z_r[0];
    end
    contrib = CONTRIB_W'(in_ch.sample) << dup_shift;
    done    = (c_r == comps_m1) && (x_r == w_mask) && (y_r == h_mask) && (z_r == d_mask);
  end

  // --------------------------------------------------------- store address
  always_comb begin
    if (mode == MODE_3D) begin
      base = (IW'(y_r >> 1) << wsh) + IW'(x_r >> 1);
    end else begin
      base = IW'(x_r >> 1);
    end
    idx_full = base * IW'(comps) + IW'(c_r);
    addr     = AW'(idx_full & IW'(STORE_SIZE - 1));
  end

  // ------------------------------------------------------- raster counters
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = ((CNTW+1)'(fifo_count) + (CNTW+1)'(s1_valid_r))
                       < (CNTW+1)'(MBD_OUT_DEPTH);

  always_comb begin
    c_nxt = c_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (c_r == comps_m1) begin
      c_nxt = '0;
      if (x_r == w_mask) begin
        x_nxt = '0;
        if (y_r == h_mask) begin
          y_nxt = '0;
          z_nxt = (z_r == d_mask) ? '0 : z_r + 1'b1;
        end else begin
          y_nxt = y_r + 1'b1;
        end
      end else begin
        x_nxt = x_r + 1'b1;
      end
    end else begin
      c_nxt = c_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_log2_r     <= CFG_W'(1);
      height_log2_r    <= CFG_W'(1);
      depth_log2_r     <= '0;
      num_components_r <= NCOMP_W'(4);
      x_r              <= '0;
      y_r              <= '0;
      z_r              <= '0;
      c_r              <= '0;
    end else if (cfg_we) begin
      // any write restarts the level
      unique case (cfg_reg_t'(cfg_index))
        CFG_WIDTH_LOG2:     width_log2_r     <= cfg_data;
        CFG_HEIGHT_LOG2:    height_log2_r    <= cfg_data;
        CFG_DEPTH_LOG2:     depth_log2_r     <= cfg_data;
        CFG_NUM_COMPONENTS: num_components_r <= cfg_data[NCOMP_W-1:0];
        default: ;
      endcase
      x_r <= '0;
      y_r <= '0;
      z_r <= '0;
      c_r <= '0;
    end else if (in_acc) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      c_r <= c_nxt;
    end
  end

  // ------------------------------------------------------- second stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_first_r   <= first;
      s1_last_r    <= last;
      s1_done_r    <= done;
      s1_mode_r    <= mode;
      s1_contrib_r <= contrib;
      s1_addr_r    <= addr;
      // the store read below misses the write-back of this same edge
      s1_fwd_r     <= s1_valid_r && (s1_addr_r == addr);
      fwd_data_r   <= sum;
    end
  end

  // read-modify-write on the partial-sum store
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      mem[s1_addr_r] <= sum;
    end
    if (in_acc) begin
      rd_data_r <= mem[addr];
    end
  end

  always_comb begin
    operand  = s1_fwd_r ? fwd_data_r : rd_data_r;
    sum_wide = s1_first_r ? (SUM_W+1)'(s1_contrib_r)
                          : (SUM_W+1)'(operand) + (SUM_W+1)'(s1_contrib_r);
    sum      = sum_wide[SUM_W-1:0];
    res_beat.avg_value  = SAMPLE_W'(sum >> s1_mode_r);
    res_beat.level_done = s1_done_r;
  end

  mbd_out_fifo #(
    .DEPTH (MBD_OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r && s1_last_r),
    .push_beat (res_beat),
    .count     (fifo_count),
    .out_ch    (out_ch)
  );

endmodule
